>>> hw/rtl/b2s_pkg.sv
package b2s_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [2:0] CfgDigestLength = 3'd0;
  localparam logic [2:0] CfgKeyLength    = 3'd1;
  localparam logic [2:0] CfgLastNode     = 3'd2;
  localparam logic [2:0] CfgKeyWordA     = 3'd3;
  localparam logic [2:0] CfgKeyWordB     = 3'd4;
  localparam logic [2:0] CfgKeyWordC     = 3'd5;
  localparam logic [2:0] CfgKeyWordD     = 3'd6;

  localparam int unsigned DefDigestLength = 32;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        3'd0: r = 32'h6A09E667;
        3'd1: r = 32'hBB67AE85;
        3'd2: r = 32'h3C6EF372;
        3'd3: r = 32'hA54FF53A;
        3'd4: r = 32'h510E527F;
        3'd5: r = 32'h9B05688C;
        3'd6: r = 32'h1F83D9AB;
        default: r = 32'h5BE0CD19;
      endcase
      return r;
    end
  endfunction

  // Message schedule: word index for round r, slot s (0..15).
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    begin
      case (r)
        4'd0: row = 64'hFEDCBA9876543210;
        4'd1: row = 64'h357B20C16DF984AE;
        4'd2: row = 64'h491763EADF250C8B;
        4'd3: row = 64'h8F04A562EBCD1397;
        4'd4: row = 64'hD386CB1EFA427509;
        4'd5: row = 64'h91EF57D438B0A6C2;
        4'd6: row = 64'hB8293670A4DEF15C;
        4'd7: row = 64'hA2684F05931CE7BD;
        4'd8: row = 64'h5A417D2C803B9EF6;
        default: row = 64'h0DC3E9BF5167482A;
      endcase
      return row[{s, 2'b00} +: 4];
    end
  endfunction

  typedef struct packed {
    logic [3:0] round;
    logic [2:0] gidx;
  } g_ctrl_t;

endpackage

>>> hw/rtl/b2s_g_unit.sv
// One half of the G function per call: an add-xor-rotate sweep over a, b, c, d.
module b2s_g_unit (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  input  logic        second_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  logic [31:0] a1, dx, d1, c1, bx, b1;

  always_comb begin
    a1 = a_i + b_i + m_i;
    dx = d_i ^ a1;
    d1 = second_i ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c1 = c_i + d1;
    bx = b_i ^ c1;
    b1 = second_i ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    a_o = a1;
    b_o = b1;
    c_o = c1;
    d_o = d1;
  end
endmodule

>>> hw/rtl/blake2s_hash_engine_top.sv
// BLAKE2s hasher. Each input transaction carries up to four message bytes;
// the hasher takes it in the idle state, then absorbs its bytes one at a
// time before it returns to idle.
// When a byte arrives after a full 64-byte block, that block is compressed
// first: 10 rounds x 8 G functions x 2 half steps through one shared G
// unit, with a setup state before and a feed-forward state after. The end-of-message
// transaction compresses the padded last block the same way and then
// presents ceil(eff_dl/4) digest transactions, one per accepted
// output. The input is not ready while a compression or digest output runs.
module blake2s_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_ABSORB, S_CINIT, S_CRUN, S_CFIN, S_OUT
  } state_t;

  state_t       state_r;
  logic [5:0]   dlen_r, klen_r;
  logic         lnode_r;
  logic [63:0]  key_r [4];
  logic [31:0]  h_r [8];
  logic [31:0]  m_r [16];
  logic [31:0]  v_r [16];
  logic [6:0]   buf_r;
  logic [63:0]  tot_r;
  logic         open_r;
  logic [31:0]  dat_r;
  logic [2:0]   cnt_r, bi_r;
  logic         eom_r, final_r;
  logic         half_r;
  b2s_pkg::g_ctrl_t gc_r;
  logic [2:0]   oi_r;
  logic [5:0]   odl_r;

  logic [5:0] eff_dl, eff_kl;
  always_comb begin
    eff_dl = (dlen_r == 6'd0) ? 6'd1 : (dlen_r > 6'd32 ? 6'd32 : dlen_r);
    eff_kl = (klen_r > 6'd32) ? 6'd32 : klen_r;
  end

  // G operand selection
  logic [3:0] ia, ib, ic, id;
  logic [31:0] ga, gb, gc, gd, gm;
  always_comb begin
    if (!gc_r.gidx[2]) begin
      ia = {2'b00, gc_r.gidx[1:0]};
      ib = 4'd4 + {2'b00, gc_r.gidx[1:0]};
      ic = 4'd8 + {2'b00, gc_r.gidx[1:0]};
      id = 4'd12 + {2'b00, gc_r.gidx[1:0]};
    end else begin
      ia = {2'b00, gc_r.gidx[1:0]};
      ib = 4'd4 + {2'b00, gc_r.gidx[1:0] + 2'd1};
      ic = 4'd8 + {2'b00, gc_r.gidx[1:0] + 2'd2};
      id = 4'd12 + {2'b00, gc_r.gidx[1:0] + 2'd3};
    end
  end
  assign gm = m_r[b2s_pkg::sigma(gc_r.round, {gc_r.gidx, half_r})];

  b2s_g_unit u_g (
    .a_i(v_r[ia]), .b_i(v_r[ib]), .c_i(v_r[ic]), .d_i(v_r[id]),
    .m_i(gm), .second_i(half_r),
    .a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
  );

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dlen_r  <= 6'(b2s_pkg::DefDigestLength);
      klen_r  <= '0;
      lnode_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= '0;
      buf_r   <= '0;
      tot_r   <= '0;
      open_r  <= 1'b0;
      out_valid <= 1'b0;
      gc_r    <= '0;
      half_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          b2s_pkg::CfgDigestLength: dlen_r <= cfg_data[5:0];
          b2s_pkg::CfgKeyLength:    klen_r <= cfg_data[5:0];
          b2s_pkg::CfgLastNode:     lnode_r <= cfg_data[0];
          b2s_pkg::CfgKeyWordA:     key_r[0] <= cfg_data;
          b2s_pkg::CfgKeyWordB:     key_r[1] <= cfg_data;
          b2s_pkg::CfgKeyWordC:     key_r[2] <= cfg_data;
          b2s_pkg::CfgKeyWordD:     key_r[3] <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dat_r <= in_data_word;
            cnt_r <= (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
            eom_r <= in_end_of_message;
            bi_r  <= '0;
            if (!open_r) begin
              for (int i = 1; i < 8; i++) h_r[i] <= b2s_pkg::iv_word(3'(i));
              h_r[0] <= b2s_pkg::iv_word(3'd0) ^
                        {8'h01, 8'h01, 2'b00, eff_kl, 2'b00, eff_dl};
              tot_r <= '0;
              open_r <= 1'b1;
              // The whole block is rewritten here, key bytes or zeros.
              for (int i = 0; i < 16; i++) begin
                if (i < 8) begin
                  for (int j = 0; j < 4; j++) begin
                    m_r[i][8*j +: 8] <= (6'(4*i+j) < eff_kl) ?
                      key_r[i/2][8*(4*(i%2)+j) +: 8] : 8'h00;
                  end
                end else begin
                  m_r[i] <= '0;
                end
              end
              buf_r <= (eff_kl != 6'd0) ? 7'd64 : 7'd0;
            end
            state_r <= S_ABSORB;
          end
        end
        S_ABSORB: begin
          if (bi_r < cnt_r) begin
            if (buf_r[6]) begin
              tot_r   <= tot_r + 64'd64;
              final_r <= 1'b0;
              state_r <= S_CINIT;
            end else begin
              if (buf_r[1:0] == 2'd0) m_r[buf_r[5:2]] <= {24'h0, dat_r[7:0]};
              else m_r[buf_r[5:2]][{buf_r[1:0], 3'b000} +: 8] <= dat_r[7:0];
              dat_r <= {8'h00, dat_r[31:8]};
              bi_r  <= bi_r + 3'd1;
              buf_r <= buf_r + 7'd1;
            end
          end else if (eom_r) begin
            tot_r <= tot_r + {57'd0, buf_r};
            for (int i = 0; i < 16; i++) begin
              for (int j = 0; j < 4; j++) begin
                if (7'(4*i+j) >= buf_r) m_r[i][8*j +: 8] <= 8'h00;
              end
            end
            final_r <= 1'b1;
            state_r <= S_CINIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CINIT: begin
          for (int i = 0; i < 8; i++) begin
            v_r[i]   <= h_r[i];
            v_r[i+8] <= b2s_pkg::iv_word(3'(i));
          end
          v_r[12] <= b2s_pkg::iv_word(3'd4) ^ tot_r[31:0];
          v_r[13] <= b2s_pkg::iv_word(3'd5) ^ tot_r[63:32];
          v_r[14] <= b2s_pkg::iv_word(3'd6) ^ {32{final_r}};
          v_r[15] <= b2s_pkg::iv_word(3'd7) ^ {32{final_r & lnode_r}};
          gc_r    <= '0;
          half_r  <= 1'b0;
          state_r <= S_CRUN;
        end
        S_CRUN: begin
          v_r[ia] <= ga;
          v_r[ib] <= gb;
          v_r[ic] <= gc;
          v_r[id] <= gd;
          half_r <= ~half_r;
          if (half_r) begin
            gc_r.gidx <= gc_r.gidx + 3'd1;
            if (gc_r.gidx == 3'd7) begin
              gc_r.round <= gc_r.round + 4'd1;
              if (gc_r.round == 4'(b2s_pkg::NumRounds - 1)) state_r <= S_CFIN;
            end
          end
        end
        S_CFIN: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] ^ v_r[i] ^ v_r[i+8];
          if (final_r) begin
            open_r    <= 1'b0;
            oi_r      <= '0;
            odl_r     <= eff_dl;
            out_valid <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            buf_r   <= '0;
            state_r <= S_ABSORB;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (out_last_word) begin
              out_valid <= 1'b0;
              state_r   <= S_IDLE;
            end else begin
              oi_r <= oi_r + 3'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [5:0] have;
  always_comb begin
    have = odl_r - {1'b0, oi_r, 2'b00};
    out_word_index = oi_r;
    out_last_word  = (have <= 6'd4);
    case (have)
      6'd1: out_digest_word = {24'h0, h_r[oi_r][7:0]};
      6'd2: out_digest_word = {16'h0, h_r[oi_r][15:0]};
      6'd3: out_digest_word = {8'h0, h_r[oi_r][23:0]};
      default: out_digest_word = h_r[oi_r];
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("out_valid outside output phase");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while presenting digest");
  a_buf_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_r <= 7'd64) else $error("buffer count overflow");
endmodule

>>> tb/tb.sv
module tb;

  localparam int unsigned QuietLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  blake2s_hash_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_word(in_data_word),
    .in_byte_count(in_byte_count), .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_ready(out_ready), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the hasher: configuration, chain, block buffer and counters.
  logic [5:0]  sh_dlen;
  logic [5:0]  sh_klen;
  logic        sh_last_node;
  logic [63:0] sh_key [4];
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [31:0] wv [16];
  int unsigned nbuf;
  logic [63:0] byte_total;
  bit          msg_open;

  digest_word_t digest_q[$];
  digest_word_t want;
  int          n_errors = 0;
  int          n_sent = 0;
  int          quiet = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          gap_left = 0;

  function automatic logic [31:0] iv_const(input int i);
    case (i)
      0: return 32'h6A09E667;
      1: return 32'hBB67AE85;
      2: return 32'h3C6EF372;
      3: return 32'hA54FF53A;
      4: return 32'h510E527F;
      5: return 32'h9B05688C;
      6: return 32'h1F83D9AB;
      default: return 32'h5BE0CD19;
    endcase
  endfunction

  // Message word schedule; slot 0 is the top nibble of each row.
  function automatic int unsigned sched(input int r, input int s);
    logic [63:0] row;
    case (r)
      0: row = 64'h0123456789ABCDEF;
      1: row = 64'hEA489FD61C02B753;
      2: row = 64'hB8C052FDAE367194;
      3: row = 64'h7931DCBE265A40F8;
      4: row = 64'h905724AFE1BC683D;
      5: row = 64'h2C6A0B834D75FE19;
      6: row = 64'hC51FED4A0763928B;
      7: row = 64'hDB7EC13950F4862A;
      8: row = 64'h6FE9B308C2D714A5;
      default: row = 64'hA2847615FB9E3CD0;
    endcase
    return {28'd0, row[63 - 4 * s -: 4]};
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void quarter_round(input int r, input int g, input int a, input int b,
                                        input int c, input int d);
    wv[a] = wv[a] + wv[b] + blk[sched(r, 2 * g)];
    wv[d] = ror(wv[d] ^ wv[a], 16);
    wv[c] = wv[c] + wv[d];
    wv[b] = ror(wv[b] ^ wv[c], 12);
    wv[a] = wv[a] + wv[b] + blk[sched(r, 2 * g + 1)];
    wv[d] = ror(wv[d] ^ wv[a], 8);
    wv[c] = wv[c] + wv[d];
    wv[b] = ror(wv[b] ^ wv[c], 7);
  endfunction

  function automatic void compress_block(input bit final_blk);
    for (int i = 0; i < 8; i++) begin
      wv[i] = chain[i];
      wv[i + 8] = iv_const(i);
    end
    wv[12] ^= byte_total[31:0];
    wv[13] ^= byte_total[63:32];
    if (final_blk) begin
      wv[14] = ~wv[14];
      if (sh_last_node) wv[15] = ~wv[15];
    end
    for (int r = 0; r < 10; r++) begin
      quarter_round(r, 0, 0, 4, 8, 12);
      quarter_round(r, 1, 1, 5, 9, 13);
      quarter_round(r, 2, 2, 6, 10, 14);
      quarter_round(r, 3, 3, 7, 11, 15);
      quarter_round(r, 4, 0, 5, 10, 15);
      quarter_round(r, 5, 1, 6, 11, 12);
      quarter_round(r, 6, 2, 7, 8, 13);
      quarter_round(r, 7, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i + 8];
  endfunction

  function automatic void store_byte(input int unsigned pos, input logic [7:0] b);
    int unsigned w;
    int unsigned sh;
    w = (pos >> 2) & 15;
    sh = (pos & 3) * 8;
    if (sh == 0) blk[w] = {24'd0, b};
    else blk[w] |= {24'd0, b} << sh;
  endfunction

  function automatic int unsigned digest_bytes();
    if (sh_dlen == 0) return 1;
    if (sh_dlen > 32) return 32;
    return sh_dlen;
  endfunction

  function automatic void start_message();
    int unsigned kl;
    kl = (sh_klen > 32) ? 32 : sh_klen;
    for (int i = 0; i < 8; i++) chain[i] = iv_const(i);
    chain[0] ^= digest_bytes() | (kl << 8) | (1 << 16) | (1 << 24);
    byte_total = '0;
    nbuf = 0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    if (kl != 0) begin
      for (int i = 0; i < kl; i++) store_byte(i, sh_key[i >> 3][(i & 7) * 8 +: 8]);
      nbuf = 64;
    end
    msg_open = 1'b1;
  endfunction

  function automatic void hash_word(input logic [31:0] d, input logic [2:0] cnt_in,
                                    input logic eom);
    int unsigned cnt;
    int unsigned dl;
    int unsigned nw;
    int unsigned have;
    digest_word_t dw;
    cnt = (cnt_in > 4) ? 4 : cnt_in;
    if (!msg_open) start_message();
    for (int i = 0; i < cnt; i++) begin
      if (nbuf >= 64) begin
        byte_total += 64;
        compress_block(1'b0);
        nbuf = 0;
      end
      store_byte(nbuf, d[8 * i +: 8]);
      nbuf++;
    end
    if (!eom) return;
    byte_total += nbuf;
    for (int p = nbuf; p < 64; p++) store_byte(p, 8'd0);
    compress_block(1'b1);
    msg_open = 1'b0;
    dl = digest_bytes();
    nw = (dl + 3) / 4;
    for (int i = 0; i < nw; i++) begin
      dw.word = chain[i];
      have = dl - 4 * i;
      if (have < 4) dw.word &= (32'd1 << (8 * have)) - 1;
      dw.index = i[2:0];
      dw.last = (i + 1 == nw);
      digest_q.push_back(dw);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("MISMATCH %s: got %h, expected %h", what, got, exp);
    n_errors++;
  endtask

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest word with none pending", out_digest_word, 32'd0);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_word_index !== want.index)
            report_mismatch("word_index", {29'd0, out_word_index}, {29'd0, want.index});
          if (out_last_word !== want.last)
            report_mismatch("last_word", {31'd0, out_last_word}, {31'd0, want.last});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > QuietLimit) begin
        $display("timeout: no transaction for %0d cycles", quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: a requested long hold, otherwise random stall bursts, or always ready when sink_idle_en is clear.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      out_ready <= 1'b0;
      hold_left <= HoldCycles - 1;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!sink_idle_en) begin
      out_ready <= 1'b1;
    end else if (gap_left > 0) begin
      out_ready <= 1'b0;
      gap_left <= gap_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      gap_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [31:0] d, input logic [2:0] cnt, input logic eom);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= d;
    in_byte_count <= cnt;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hash_word(d, cnt, eom);
    n_sent++;
  endtask

  // Body words carry four bytes, or any count when mixed is set.
  task automatic send_message(input int n_items, input bit mixed, input logic [2:0] last_cnt);
    logic [2:0] c;
    for (int i = 0; i < n_items - 1; i++) begin
      c = mixed ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, c, 1'b0);
    end
    send_word($urandom, last_cnt, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    // The digest is the last thing the block does, but leave slack for the tail.
    repeat (200) @(posedge clk);
  endtask

  task automatic write_config(input logic [5:0] dlen, input logic [5:0] klen, input logic ln,
                              input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3);
    logic [2:0]  idx [7];
    logic [63:0] val [7];
    idx = '{b2s_pkg::CfgDigestLength, b2s_pkg::CfgKeyLength, b2s_pkg::CfgLastNode,
            b2s_pkg::CfgKeyWordA, b2s_pkg::CfgKeyWordB, b2s_pkg::CfgKeyWordC,
            b2s_pkg::CfgKeyWordD};
    val = '{{58'd0, dlen}, {58'd0, klen}, {63'd0, ln}, k0, k1, k2, k3};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sh_dlen = dlen;
    sh_klen = klen;
    sh_last_node = ln;
    sh_key[0] = k0;
    sh_key[1] = k1;
    sh_key[2] = k2;
    sh_key[3] = k3;
  endtask

  task automatic random_config();
    logic [5:0] dl;
    logic [5:0] kl;
    case ($urandom_range(0, 5))
      0: dl = 6'd1;
      1: dl = 6'd32;
      2: dl = 6'($urandom_range(0, 63));
      default: dl = 6'($urandom_range(1, 32));
    endcase
    case ($urandom_range(0, 4))
      0: kl = 6'd0;
      1: kl = 6'd32;
      2: kl = 6'($urandom_range(33, 63));
      default: kl = 6'($urandom_range(1, 31));
    endcase
    write_config(dl, kl, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_directed();
    // Unkeyed, empty message, then the classic three-byte message.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h00636261, 3'd3, 1'b1);
    // Counts above four are treated as four; all-ones and all-zero data.
    send_word(32'hFFFFFFFF, 3'd7, 1'b0);
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hFFFFFFFF, 3'd6, 1'b1);
    // Exactly one block, then one byte past a block.
    send_message(16, 1'b0, 3'd4);
    send_message(17, 1'b0, 3'd1);
    wait_drained();
    // Shortest digest with a full key and last-node flag.
    write_config(6'd1, 6'd32, 1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFFFFFFFFFFFFFFFF,
                 64'h0123456789ABCDEF);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hA5A5A5A5, 3'd2, 1'b1);
    wait_drained();
    // Out-of-range digest and key lengths clamp.
    write_config(6'd0, 6'd63, 1'b0, 64'h1, 64'h2, 64'h3, 64'h4);
    send_word(32'h12345678, 3'd4, 1'b1);
    wait_drained();
    write_config(6'd63, 6'd5, 1'b1, 64'hFEDCBA9876543210, 64'h0, 64'h0, 64'h0);
    send_word(32'h0, 3'd0, 1'b1);
    send_message(3, 1'b1, 3'd4);
    wait_drained();
  endtask

  task automatic test_random(input int item_goal);
    int n_msgs;
    while (n_sent < item_goal) begin
      random_config();
      n_msgs = $urandom_range(1, 4);
      for (int m = 0; m < n_msgs; m++) begin
        if ($urandom_range(0, 9) == 0)
          send_message($urandom_range(16, 40), 1'($urandom), 3'd4);
        else send_message($urandom_range(1, 12), 1'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7)));
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_config(6'd32, 6'd0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
    // Hold the receiver; the next message then waits at the input behind the digest.
    hold_req++;
    send_message(2, 1'b0, 3'd4);
    send_message(6, 1'b0, 3'd3);
    wait_drained();
  endtask

  initial begin
    sh_dlen = 6'(b2s_pkg::DefDigestLength);
    sh_klen = '0;
    sh_last_node = 1'b0;
    for (int i = 0; i < 4; i++) sh_key[i] = '0;
    for (int i = 0; i < 8; i++) chain[i] = '0;
    nbuf = 0;
    byte_total = '0;
    msg_open = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(270);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(310);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
